FILE: rtl/wmed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmed_pkg
// Shared types for the window median unit: word structs, controller states,
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wmed_pkg;

    localparam int unsigned SampleWidth = 32;
    localparam int unsigned CountWidth  = 7;

    typedef struct packed {
        logic signed [SampleWidth-1:0] sample;
        logic                          last;
    } in_word_t;

    typedef struct packed {
        logic signed [SampleWidth-1:0] median;
        logic [CountWidth-1:0]         count;
        logic                          overflow;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MED_RD,
        ST_MED_OUT
    } wmed_state_t;

    // read address source
    typedef enum logic [1:0] {
        RD_KEPT_M1,
        RD_POS_M2,
        RD_MID
    } rd_sel_t;

    // write data source
    typedef enum logic {
        WR_VALUE,
        WR_SHIFT
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    drop;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    dec_pos;
        logic    inc_kept;
        logic    out_load;
    } wmed_cmd_t;

    typedef struct packed {
        logic full;
        logic kept_zero;
        logic pos_zero;
        logic pos_one;
        logic greater;
        logic in_last;
        logic last;
        logic out_free;
    } wmed_status_t;

endpackage

`default_nettype wire

FILE: rtl/wmed_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmed_ctrl
// Sequencer for insertion and median readout. Drives datapath commands from
// its status flags.
// ----------------------------------------------------------------------------
module wmed_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire wmed_pkg::wmed_status_t status,
    output wmed_pkg::wmed_cmd_t        cmd
);
    import wmed_pkg::*;

    wmed_state_t state_reg;
    wmed_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.rd_sel   = RD_KEPT_M1;
        cmd.wr_sel   = WR_VALUE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (status.full) begin
                        cmd.drop   = 1'b1;
                        state_next = status.in_last ? ST_MED_RD : ST_IDLE;
                    end else begin
                        cmd.load   = 1'b1;
                        cmd.rd_en  = !status.kept_zero;
                        cmd.rd_sel = RD_KEPT_M1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.wr_en = 1'b1;
                if (status.pos_zero || !status.greater) begin
                    cmd.wr_sel   = WR_VALUE;
                    cmd.inc_kept = 1'b1;
                    state_next   = status.last ? ST_MED_RD : ST_IDLE;
                end else begin
                    // move neighbor up one slot, fetch the next one down
                    cmd.wr_sel  = WR_SHIFT;
                    cmd.dec_pos = 1'b1;
                    cmd.rd_en   = !status.pos_one;
                    cmd.rd_sel  = RD_POS_M2;
                end
            end
            ST_MED_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_MID;
                state_next = ST_MED_OUT;
            end
            ST_MED_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/wmed_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmed_datapath
// Sorted sample memory, insertion position, window count, drop flag and the
// result register.
// ----------------------------------------------------------------------------
module wmed_datapath #(
    parameter int unsigned MAX_SAMPLES = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire wmed_pkg::in_word_t     s_data,
    output wmed_pkg::out_word_t         m_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    input  wire wmed_pkg::wmed_cmd_t    cmd,
    output wmed_pkg::wmed_status_t      status
);
    import wmed_pkg::*;

    localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

    logic signed [SampleWidth-1:0] store_mem [MAX_SAMPLES];

    logic signed [SampleWidth-1:0] value_reg;
    logic                          last_reg;
    logic [CW-1:0]                 pos_reg;
    logic [CW-1:0]                 kept_reg;
    logic                          dropped_reg;
    logic signed [SampleWidth-1:0] rd_data_reg;
    out_word_t                     out_reg;
    logic                          out_valid_reg;

    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic signed [SampleWidth-1:0] wr_data;

    always_comb begin
        case (cmd.rd_sel)
            RD_KEPT_M1: rd_addr = AW'(kept_reg - 1'b1);
            RD_POS_M2:  rd_addr = AW'(pos_reg - CW'(2));
            RD_MID:     rd_addr = AW'(kept_reg >> 1);
            default:    rd_addr = '0;
        endcase
    end

    assign wr_addr = AW'(pos_reg);
    assign wr_data = (cmd.wr_sel == WR_SHIFT) ? rd_data_reg : value_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_data.sample;
            last_reg  <= s_data.last;
            pos_reg   <= kept_reg;
        end else if (cmd.dec_pos) begin
            pos_reg <= pos_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                kept_reg    <= '0;
                dropped_reg <= 1'b0;
            end else begin
                if (cmd.inc_kept) begin
                    kept_reg <= kept_reg + 1'b1;
                end
                if (cmd.drop) begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.median   <= rd_data_reg;
            out_reg.count    <= CountWidth'(kept_reg);
            out_reg.overflow <= dropped_reg;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

    assign status.full      = (kept_reg == CW'(MAX_SAMPLES));
    assign status.kept_zero = (kept_reg == '0);
    assign status.pos_zero  = (pos_reg == '0);
    assign status.pos_one   = (pos_reg == CW'(1));
    assign status.greater   = (rd_data_reg > value_reg);
    assign status.in_last   = s_data.last;
    assign status.last      = last_reg;
    assign status.out_free  = !out_valid_reg || m_ready;

`ifndef NO_ASSERTIONS
    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_reg <= CW'(MAX_SAMPLES))
        else $error("kept count above capacity");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (pos_reg <= kept_reg) && (kept_reg < CW'(MAX_SAMPLES)))
        else $error("insert write outside kept range");

    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (kept_reg != '0))
        else $error("result from empty window");

    a_no_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten");

    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (kept_reg == '0) && !dropped_reg)
        else $error("window state not cleared after result");
`endif

endmodule

`default_nettype wire

FILE: rtl/window_median_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_median_unit
// Sort-based median over a window of Q16.16 samples; one result word per
// window, on the sample word marked last.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  s_      | in  | s_valid / s_ready  | sample, last
//  m_      | out | m_valid / m_ready  | median, count, overflow
//
// A kept sample is inserted by walking the sorted memory one entry per cycle,
// past every stored sample larger than it, through its single read and write
// port. A sample arriving with the window full is dropped and sets overflow.
// The last word of a window is followed by the median read and result load.
// Reset (aresetn low, synchronous) empties the window; memory is not cleared.
// A pending result stalls only the final step of the next window.
// ----------------------------------------------------------------------------
module window_median_unit #(
    parameter int unsigned MAX_SAMPLES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire wmed_pkg::in_word_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output wmed_pkg::out_word_t     m_data
);
    import wmed_pkg::*;

    wmed_cmd_t    cmd;
    wmed_status_t status;

    wmed_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wmed_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

`default_nettype wire
